/* rtl/hpti_pkg.sv */
// Shared types, constants and register map for the hashed page table insert block.
`default_nettype none

package hpti_pkg;

  // Default sizes of the tables
  localparam int GROUP_COUNT_LOG_DEF = 10;
  localparam int SEG_WAYS_DEF        = 8;
  localparam int PTE_WAYS_DEF        = 8;

  // Segment table geometry and address layout
  localparam int SEG_GROUPS = 32;
  localparam int SEG_SEL_W  = 5;
  localparam int SEG_SHIFT  = 28;
  localparam int ESID_W     = 36;
  localparam int VSID_W     = 51;
  localparam logic [14:0] VSID_PREFIX = 15'h7FFF;

  // PTE word layout
  localparam int API_LSB    = 23;
  localparam int API_W      = 5;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 64;
  localparam logic [PAGE_SHIFT-1:0] PTE_LOW_ATTR = 12'h012;  // WIMG 0010, PP 2

  // Hash sizing
  localparam logic [3:0] MIN_LOG_PTE        = 4'd4;
  localparam logic [3:0] PTES_PER_GROUP_LOG = 4'd3;

  // Configuration port and register widths
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int LOG_W       = 4;
  localparam int VSID_MASK_W = 39;
  localparam int SHIFT_W     = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_PTE_COUNT = 8'd0,
    REG_VSID_MASK     = 8'd1,
    REG_VA_MASK       = 8'd2,
    REG_VA_SHIFT      = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_MAPPED   = 2'd0,
    ST_SEG_FULL = 2'd1,
    ST_PTE_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_SEG,
    S_PTE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [LOG_W-1:0]       log_pte_count;
    logic [VSID_MASK_W-1:0] vsid_mask;
    logic [ADDR_W-1:0]      va_mask;
    logic [SHIFT_W-1:0]     va_shift;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    log_pte_count: 4'd13,
    vsid_mask:     39'h7F_FFFF_FFFF,
    va_mask:       64'h0000_0000_0FFF_F000,
    va_shift:      6'd12
  };

endpackage

`default_nettype wire

/* rtl/hpti_hash.sv */
// Page table group hash: masked VSID xor masked, shifted address, cut to the group width.
`default_nettype none

module hpti_hash #(
  parameter int GROUP_COUNT_LOG = hpti_pkg::GROUP_COUNT_LOG_DEF
) (
  input  hpti_pkg::cfg_t              cfg,
  input  logic [hpti_pkg::ADDR_W-1:0] virt_addr,
  output logic [GROUP_COUNT_LOG-1:0]  group
);

  logic [hpti_pkg::LOG_W-1:0]  log_eff;
  logic [hpti_pkg::LOG_W-1:0]  width;
  logic [hpti_pkg::ESID_W-1:0] esid;
  logic [hpti_pkg::VSID_W-1:0] vsid;
  logic [hpti_pkg::ADDR_W-1:0] ea_term;
  logic [hpti_pkg::ADDR_W-1:0] hash;
  logic [GROUP_COUNT_LOG-1:0]  mask;

  always_comb begin
    // small tables clamp to the minimum size
    log_eff = (cfg.log_pte_count < hpti_pkg::MIN_LOG_PTE) ? hpti_pkg::MIN_LOG_PTE
                                                          : cfg.log_pte_count;
    width   = log_eff - hpti_pkg::PTES_PER_GROUP_LOG;
    esid    = virt_addr[hpti_pkg::SEG_SHIFT +: hpti_pkg::ESID_W];
    vsid    = {hpti_pkg::VSID_PREFIX, esid};
    ea_term = (virt_addr & cfg.va_mask) >> cfg.va_shift;
    hash    = hpti_pkg::ADDR_W'(vsid[hpti_pkg::VSID_MASK_W-1:0] & cfg.vsid_mask) ^ ea_term;
    // a width beyond the group index saturates: every bit stays set
    for (int j = 0; j < GROUP_COUNT_LOG; j++) begin
      mask[j] = (j < int'(width));
    end
    group = hash[GROUP_COUNT_LOG-1:0] & mask;
  end

endmodule

`default_nettype wire

/* rtl/hashed_page_table_insert.sv */
// Top level: segment lookup and hashed page table insert under a small sequencer.
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: virt_addr, phys_addr
//  m_axis    out  m_axis_tvalid/tready        tuser: status; tdata: result fields
//  cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// The result is registered through S_HASH, S_SEG and S_PTE (no S_PTE on a full segment group),
// and S_SEG examines k = 1..SEG_WAYS segment ways, one per cycle on the ESID memory read port.
// One item in flight; input is ready again in the cycle after the result word is taken.
// After reset a clearing pass writes all 2**GROUP_COUNT_LOG page valid rows (1024 by default),
// one a cycle; config writes are taken meanwhile and cfg_ready is always high.
`default_nettype none

module hashed_page_table_insert #(
  parameter int GROUP_COUNT_LOG = hpti_pkg::GROUP_COUNT_LOG_DEF,
  parameter int SEG_WAYS        = hpti_pkg::SEG_WAYS_DEF,
  parameter int PTE_WAYS        = hpti_pkg::PTE_WAYS_DEF,
  localparam int SLOT_W = (PTE_WAYS > 1) ? $clog2(PTE_WAYS) : 1,
  localparam int OUT_W  = 1 + GROUP_COUNT_LOG + SLOT_W + 2 * hpti_pkg::ADDR_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [2*hpti_pkg::ADDR_W-1:0]   s_axis_tdata,  // virt_addr, phys_addr
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [1:0]                      m_axis_tuser,  // status
  // segment_created, group_index, slot_index, entry_high, entry_low, zero pad
  output logic [OUT_TW-1:0]               m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hpti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpti_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int GROUP_COUNT = 1 << GROUP_COUNT_LOG;
  localparam int SEG_ENTRIES = hpti_pkg::SEG_GROUPS * SEG_WAYS;
  localparam int SEG_AW      = $clog2(SEG_ENTRIES);
  localparam int WAY_W       = (SEG_WAYS > 1) ? $clog2(SEG_WAYS) : 1;
  localparam int PTE_ENTRIES = GROUP_COUNT * PTE_WAYS;
  localparam int PTE_AW      = (PTE_ENTRIES > 1) ? $clog2(PTE_ENTRIES) : 1;
  localparam int AW          = hpti_pkg::ADDR_W;

  hpti_pkg::state_t state, state_next;
  hpti_pkg::cfg_t   cfg;

  logic [AW-1:0]               va_r;
  logic [AW-1:0]               pa_r;
  logic [GROUP_COUNT_LOG-1:0]  group_r;
  logic [GROUP_COUNT_LOG-1:0]  group_hash;
  logic [GROUP_COUNT_LOG-1:0]  clr_cnt;
  logic [WAY_W-1:0]            way_r;
  logic [WAY_W-1:0]            way_next;

  logic [SEG_ENTRIES-1:0]      seg_valid;
  logic [hpti_pkg::ESID_W-1:0] seg_mem [SEG_ENTRIES];
  logic [hpti_pkg::ESID_W-1:0] seg_q;
  logic [SEG_AW-1:0]           seg_base;
  logic [SEG_AW-1:0]           seg_cur_addr;
  logic [SEG_AW-1:0]           seg_rd_addr;
  logic                        seg_free;
  logic                        seg_hit;
  logic                        seg_full;
  logic                        found_r;

  logic [PTE_WAYS-1:0]         pv_mem [GROUP_COUNT];
  logic [PTE_WAYS-1:0]         pv_q;
  logic [PTE_WAYS-1:0]         pv_wdata;
  logic [GROUP_COUNT_LOG-1:0]  pv_waddr;
  logic                        pv_we;
  logic [2*AW-1:0]             pte_mem [PTE_ENTRIES];
  logic [PTE_AW-1:0]           pte_addr;

  logic [SLOT_W-1:0]           free_slot;
  logic                        slot_avail;
  logic [PTE_WAYS-1:0]         slot_onehot;
  logic                        claim;
  logic [hpti_pkg::ESID_W-1:0] esid;
  logic [AW-1:0]               entry_high;
  logic [AW-1:0]               entry_low;

  hpti_pkg::status_t           status_r;
  logic                        created_r;
  logic [SLOT_W-1:0]           slot_r;
  logic [AW-1:0]               hi_r;
  logic [AW-1:0]               lo_r;

  hpti_hash #(
    .GROUP_COUNT_LOG(GROUP_COUNT_LOG)
  ) u_hash (
    .cfg      (cfg),
    .virt_addr(va_r),
    .group    (group_hash)
  );

  // Datapath decode
  always_comb begin
    esid         = va_r[hpti_pkg::SEG_SHIFT +: hpti_pkg::ESID_W];
    seg_base     = SEG_AW'(32'(va_r[hpti_pkg::SEG_SHIFT +: hpti_pkg::SEG_SEL_W]) * SEG_WAYS);
    seg_cur_addr = seg_base + SEG_AW'(way_r);
    seg_rd_addr  = seg_base + SEG_AW'(way_next);
    seg_free     = !seg_valid[seg_cur_addr];
    seg_hit      = !seg_free && (seg_q == esid);
    seg_full     = !seg_free && !seg_hit && (way_r == WAY_W'(SEG_WAYS - 1));

    // first invalid slot in the group row
    slot_avail = 1'b0;
    free_slot  = '0;
    for (int k = PTE_WAYS - 1; k >= 0; k--) begin
      if (!pv_q[k]) begin
        slot_avail = 1'b1;
        free_slot  = SLOT_W'(k);
      end
    end
    slot_onehot = PTE_WAYS'(1) << free_slot;
    pte_addr    = PTE_AW'(32'(group_r) * PTE_WAYS) + PTE_AW'(free_slot);

    entry_high = {1'b0, hpti_pkg::VSID_PREFIX, esid,
                  va_r[hpti_pkg::API_LSB +: hpti_pkg::API_W], 6'b0, 1'b1};
    entry_low  = {pa_r[AW-1:hpti_pkg::PAGE_SHIFT], hpti_pkg::PTE_LOW_ATTR};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpti_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    way_next      = way_r;
    claim         = 1'b0;
    s_axis_tready = 1'b0;
    case (state)
      hpti_pkg::S_CLEAR: begin
        if (&clr_cnt) state_next = hpti_pkg::S_IDLE;
      end
      hpti_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = hpti_pkg::S_HASH;
      end
      hpti_pkg::S_HASH: begin
        way_next   = '0;
        state_next = hpti_pkg::S_SEG;
      end
      hpti_pkg::S_SEG: begin
        if (seg_free || seg_hit) begin
          state_next = hpti_pkg::S_PTE;
        end else if (seg_full) begin
          state_next = hpti_pkg::S_OUT;
        end else begin
          way_next = way_r + 1'b1;
        end
      end
      hpti_pkg::S_PTE: begin
        claim      = slot_avail;
        state_next = hpti_pkg::S_OUT;
      end
      hpti_pkg::S_OUT: begin
        if (m_axis_tready) state_next = hpti_pkg::S_IDLE;
      end
      default: state_next = hpti_pkg::S_IDLE;
    endcase
  end

  // Control registers: config, clear counter, segment valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg       <= hpti_pkg::CFG_RESET;
      clr_cnt   <= '0;
      seg_valid <= '0;
    end else begin
      if (state == hpti_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_valid) begin
        case (cfg_index)
          hpti_pkg::REG_LOG_PTE_COUNT:
            cfg.log_pte_count <= cfg_data[hpti_pkg::LOG_W-1:0];
          hpti_pkg::REG_VSID_MASK:
            cfg.vsid_mask     <= cfg_data[hpti_pkg::VSID_MASK_W-1:0];
          hpti_pkg::REG_VA_MASK:
            cfg.va_mask       <= cfg_data[AW-1:0];
          hpti_pkg::REG_VA_SHIFT:
            cfg.va_shift      <= cfg_data[hpti_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (claim && !found_r) seg_valid[seg_cur_addr] <= 1'b1;
    end
  end

  // Item registers and result word
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      va_r <= s_axis_tdata[AW-1:0];
      pa_r <= s_axis_tdata[2*AW-1:AW];
    end
    if (state == hpti_pkg::S_HASH) group_r <= group_hash;
    way_r <= way_next;
    if (state == hpti_pkg::S_SEG) found_r <= seg_hit;

    if (state == hpti_pkg::S_SEG && seg_full) begin
      status_r  <= hpti_pkg::ST_SEG_FULL;
      created_r <= 1'b0;
      slot_r    <= '0;
      hi_r      <= '0;
      lo_r      <= '0;
    end
    if (state == hpti_pkg::S_PTE) begin
      if (slot_avail) begin
        status_r  <= hpti_pkg::ST_MAPPED;
        created_r <= !found_r;
        slot_r    <= free_slot;
        hi_r      <= entry_high;
        lo_r      <= entry_low;
      end else begin
        status_r  <= hpti_pkg::ST_PTE_FULL;
        created_r <= 1'b0;
        slot_r    <= '0;
        hi_r      <= '0;
        lo_r      <= '0;
      end
    end
  end

  // Segment ESID memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    seg_q <= seg_mem[seg_rd_addr];
    if (claim && !found_r) seg_mem[seg_cur_addr] <= esid;
  end

  // Page valid rows: clear sweep after reset, then read-modify-write on claim
  always_comb begin
    pv_we    = (state == hpti_pkg::S_CLEAR) || claim;
    pv_waddr = (state == hpti_pkg::S_CLEAR) ? clr_cnt : group_r;
    pv_wdata = (state == hpti_pkg::S_CLEAR) ? '0 : (pv_q | slot_onehot);
  end

  always_ff @(posedge clk) begin
    pv_q <= pv_mem[group_r];
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
  end

  // Page table entries
  always_ff @(posedge clk) begin
    if (claim) pte_mem[pte_addr] <= {entry_high, entry_low};
  end

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = (state == hpti_pkg::S_OUT);
  assign m_axis_tuser  = status_r;
  assign m_axis_tdata  = OUT_TW'({lo_r, hi_r, slot_r, group_r, created_r});

  // Checks
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_pte_full: assert property (@(posedge clk) disable iff (rst)
    (state == hpti_pkg::S_PTE && (&pv_q)) |=> (m_axis_tuser == hpti_pkg::ST_PTE_FULL))
    else $error("full page group not reported");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != hpti_pkg::ST_MAPPED) |->
      (!created_r && slot_r == '0 && hi_r == '0 && lo_r == '0))
    else $error("failed insert carries entry data");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |->
      ($past(state) == hpti_pkg::S_PTE || $past(state) == hpti_pkg::S_SEG))
    else $error("result raised outside search or insert");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the hashed page table insert block: corners, settings sweep, maps.
`default_nettype none

module testbench;

  localparam int GROUP_W  = hpti_pkg::GROUP_COUNT_LOG_DEF;
  localparam int SLOT_W   = $clog2(hpti_pkg::PTE_WAYS_DEF);
  localparam int POOL_LEN = 32;

  // Result word as it leaves on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [1:0]                  pad;
    logic [hpti_pkg::ADDR_W-1:0] entry_low;
    logic [hpti_pkg::ADDR_W-1:0] entry_high;
    logic [SLOT_W-1:0]           slot;
    logic [GROUP_W-1:0]          group;
    logic                        seg_new;
  } result_word_t;

  typedef struct {
    hpti_pkg::status_t           status;
    logic                        seg_new;
    logic [GROUP_W-1:0]          group;
    logic [SLOT_W-1:0]           slot;
    logic [hpti_pkg::ADDR_W-1:0] entry_high;
    logic [hpti_pkg::ADDR_W-1:0] entry_low;
  } map_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [2*hpti_pkg::ADDR_W-1:0]     s_axis_tdata  = '0;  // virt_addr, phys_addr
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [1:0]                        m_axis_tuser;        // status
  // segment_created, group_index, slot_index, entry_high, entry_low, zero pad
  logic [$bits(result_word_t)-1:0]   m_axis_tdata;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [hpti_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [hpti_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

  hashed_page_table_insert DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // Mirror of the block's tables and registers
  logic [hpti_pkg::LOG_W-1:0]       cfg_log   = hpti_pkg::CFG_RESET.log_pte_count;
  logic [hpti_pkg::VSID_MASK_W-1:0] cfg_vmask = hpti_pkg::CFG_RESET.vsid_mask;
  logic [hpti_pkg::ADDR_W-1:0]      cfg_emask = hpti_pkg::CFG_RESET.va_mask;
  logic [hpti_pkg::SHIFT_W-1:0]     cfg_shift = hpti_pkg::CFG_RESET.va_shift;

  bit                          seg_used [hpti_pkg::SEG_GROUPS*hpti_pkg::SEG_WAYS_DEF];
  logic [hpti_pkg::ESID_W-1:0] seg_tag  [hpti_pkg::SEG_GROUPS*hpti_pkg::SEG_WAYS_DEF];
  bit                          pte_used [(1 << GROUP_W)*hpti_pkg::PTE_WAYS_DEF];

  map_result_t                 expected_maps[$];
  logic [hpti_pkg::ESID_W-1:0] esid_pool [POOL_LEN];
  int                          mismatches = 0;
  bit                          idling = 1'b1;
  int                          stall_left = 0;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [GROUP_W-1:0] hash_group(input logic [63:0] va,
                                                    input logic [63:0] vsid);
    int width;
    logic [63:0] mix;
    width = int'(((cfg_log < hpti_pkg::MIN_LOG_PTE) ? hpti_pkg::MIN_LOG_PTE : cfg_log)
                 - hpti_pkg::PTES_PER_GROUP_LOG);
    if (width > GROUP_W) width = GROUP_W;
    mix = (vsid & 64'(cfg_vmask)) ^ ((va & cfg_emask) >> cfg_shift);
    return GROUP_W'(mix & ((64'd1 << width) - 64'd1));
  endfunction

  function automatic void apply_config(input logic [hpti_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [63:0] data);
    case (idx)
      hpti_pkg::REG_LOG_PTE_COUNT: cfg_log   = data[hpti_pkg::LOG_W-1:0];
      hpti_pkg::REG_VSID_MASK:     cfg_vmask = data[hpti_pkg::VSID_MASK_W-1:0];
      hpti_pkg::REG_VA_MASK:       cfg_emask = data;
      hpti_pkg::REG_VA_SHIFT:      cfg_shift = data[hpti_pkg::SHIFT_W-1:0];
      default: ;
    endcase
  endfunction

  // Predict one map and update the mirrored tables
  function automatic void predict_map(input logic [63:0] va, input logic [63:0] pa);
    logic [hpti_pkg::ESID_W-1:0] esid;
    logic [63:0] vsid;
    int base, way, slot, pbase;
    bit found;
    map_result_t r;
    esid  = va[hpti_pkg::SEG_SHIFT +: hpti_pkg::ESID_W];
    vsid  = {13'b0, hpti_pkg::VSID_PREFIX, esid};
    base  = int'(va[hpti_pkg::SEG_SHIFT +: hpti_pkg::SEG_SEL_W]) * hpti_pkg::SEG_WAYS_DEF;
    found = 1'b0;
    r.status = hpti_pkg::ST_MAPPED;
    r.seg_new = 1'b0;
    r.group = hash_group(va, vsid);
    r.slot = '0;
    r.entry_high = '0;
    r.entry_low = '0;
    pbase = int'(r.group) * hpti_pkg::PTE_WAYS_DEF;
    for (way = 0; way < hpti_pkg::SEG_WAYS_DEF; way++) begin
      if (!seg_used[base + way]) break;
      if (seg_tag[base + way] == esid) begin
        found = 1'b1;
        break;
      end
    end
    if (!found && way >= hpti_pkg::SEG_WAYS_DEF) begin
      r.status = hpti_pkg::ST_SEG_FULL;
    end else begin
      for (slot = 0; slot < hpti_pkg::PTE_WAYS_DEF; slot++)
        if (!pte_used[pbase + slot]) break;
      if (slot >= hpti_pkg::PTE_WAYS_DEF) begin
        // page group full: leave the segment table alone too
        r.status = hpti_pkg::ST_PTE_FULL;
      end else begin
        if (!found) begin
          seg_used[base + way] = 1'b1;
          seg_tag[base + way] = esid;
        end
        pte_used[pbase + slot] = 1'b1;
        r.seg_new = !found;
        r.slot = SLOT_W'(slot);
        r.entry_high = (vsid << hpti_pkg::PAGE_SHIFT)
                     | (64'(va[hpti_pkg::API_LSB +: hpti_pkg::API_W]) << 7) | 64'd1;
        r.entry_low = {pa[hpti_pkg::ADDR_W-1:hpti_pkg::PAGE_SHIFT], hpti_pkg::PTE_LOW_ATTR};
      end
    end
    expected_maps.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Receiver: stall in bursts while idling is on
  always @(posedge clk) begin
    if (idling && stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    map_result_t  want;
    result_word_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_word_t'(m_axis_tdata);
      if (expected_maps.size() == 0) begin
        $display("%0t: result word with none expected, actual status %h data %h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_maps.pop_front();
        check_field("status", 64'(want.status), 64'(m_axis_tuser));
        check_field("segment_created", 64'(want.seg_new), 64'(got.seg_new));
        check_field("group_index", 64'(want.group), 64'(got.group));
        check_field("slot_index", 64'(want.slot), 64'(got.slot));
        check_field("entry_high", want.entry_high, got.entry_high);
        check_field("entry_low", want.entry_low, got.entry_low);
      end
    end
  end

  // Send one map request word; leaves tvalid high for the caller to drop or reuse
  task automatic send_map(input logic [63:0] va, input logic [63:0] pa);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pa, va};
    do @(posedge clk); while (!s_axis_tready);
    predict_map(va, pa);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hpti_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_config(idx, data);
  endtask

  // Drain, then write every register plus one unmapped index
  task automatic load_settings(input logic [63:0] log_w, input logic [63:0] vmask_w,
                               input logic [63:0] emask_w, input logic [63:0] shift_w);
    wait_for_drain();
    write_reg(hpti_pkg::REG_LOG_PTE_COUNT, log_w);
    write_reg(hpti_pkg::REG_VSID_MASK, vmask_w);
    write_reg(hpti_pkg::REG_VA_MASK, emask_w);
    write_reg(hpti_pkg::REG_VA_SHIFT, shift_w);
    write_reg(hpti_pkg::CFG_IDX_W'($urandom_range(int'(hpti_pkg::REG_VA_SHIFT) + 1, 255)),
              rand64());
    cfg_valid <= 1'b0;
  endtask

  // Mostly reuse a pool of segments so lookups hit; some fully random addresses
  function automatic logic [63:0] pick_virt_addr();
    if ($urandom_range(0, 9) < 2) return rand64();
    return {esid_pool[$urandom_range(0, POOL_LEN - 1)], 28'($urandom())};
  endfunction

  task automatic run_random_maps(input int count);
    repeat (count) send_map(pick_virt_addr(), rand64());
  endtask

  task automatic test_directed_corners();
    int k;
    send_map('0, '0);
    send_map('1, '1);
    // same page again until its group overflows
    repeat (8) send_map('0, rand64());
    // nine segments in one segment group: the last finds it full
    for (k = 1; k <= 9; k++)
      send_map((64'(k) << 33) | (64'd5 << hpti_pkg::SEG_SHIFT), rand64());
    // new segment hashing into the full group must not claim a way
    send_map((64'd1 << hpti_pkg::SEG_SHIFT) | (64'd1 << hpti_pkg::PAGE_SHIFT), rand64());
    send_map(64'd1 << hpti_pkg::SEG_SHIFT, rand64());
  endtask

  task automatic test_hash_settings();
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_settings(64'd0, 64'd0, '1, 64'd0);
        1: load_settings(64'd15, 64'h7F_FFFF_FFFF, 64'd0, 64'd63);
        2: load_settings(64'd4, '1, '1, 64'd12);
        3: load_settings(64'd13, rand64(), rand64(), 64'($urandom_range(0, 63)));
        default: load_settings(rand64(), rand64(), rand64(), rand64());
      endcase
      idling = ($urandom_range(0, 3) != 0);
      run_random_maps(38);
    end
  endtask

  task automatic test_drain_pause();
    load_settings(64'd13, 64'h7F_FFFF_FFFF, 64'h0000_0000_0FFF_F000, 64'd12);
    idling = 1'b1;
    run_random_maps(50);
    wait_for_drain();
    repeat ($urandom_range(5, 30)) @(posedge clk);
    run_random_maps(50);
  endtask

  task automatic test_steady_tail();
    load_settings(64'd11, rand64(), 64'h0000_00FF_FFFF_F000, 64'd8);
    idling = 1'b0;
    run_random_maps(60);
  endtask

  initial begin
    foreach (esid_pool[i]) esid_pool[i] = hpti_pkg::ESID_W'(rand64());
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_hash_settings();
    test_drain_pause();
    test_steady_tail();
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
